@@ rtl/core/khr_pkg.sv @@
// Shared widths, codes and types of the key hold and repeat event generator.
`default_nettype none

package khr_pkg;

	localparam int MASK_W    = 6;
	localparam int CNT_W     = 8;
	localparam int THR_W     = 7;
	localparam int KEY_IDX_W = 3;
	localparam int KIND_W    = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'd1;

	localparam logic [THR_W-1:0] LONG_PRESS_RESET    = 7'd10;
	localparam logic [THR_W-1:0] REPEAT_PERIOD_RESET = 7'd5;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

	typedef enum logic [KIND_W-1:0] {
		EV_PRESS   = 3'd0,
		EV_LONG    = 3'd1,
		EV_REPEAT  = 3'd2,
		EV_SHORT   = 3'd3,
		EV_RELEASE = 3'd4
	} ev_kind_t;

	// Position of an event among the four slots that one key owns.
	typedef enum logic [1:0] {
		SLOT_PRESS   = 2'd0,
		SLOT_LONGREP = 2'd1,
		SLOT_SHORT   = 2'd2,
		SLOT_RELEASE = 2'd3
	} slot_t;

	typedef struct packed {
		logic press_ev;
		logic lr_ev;
		logic rep_sel;
		logic short_ev;
		logic rel_ev;
	} lane_ev_t;

endpackage

`default_nettype wire

@@ rtl/core/khr_intf.sv @@
// Channel interfaces of the key hold and repeat event generator.
`default_nettype none

interface khr_frame_if;
	import khr_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [MASK_W-1:0] pressed_mask;
	logic [MASK_W-1:0] held_mask;
	logic [MASK_W-1:0] released_mask;
	modport source (output valid, cmd, pressed_mask, held_mask, released_mask, input ready);
	modport sink (input valid, cmd, pressed_mask, held_mask, released_mask, output ready);
endinterface

interface khr_event_if;
	import khr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [KEY_IDX_W-1:0] key_id;
	logic [KIND_W-1:0]    event_kind;
	logic                 last_event;
	modport source (output valid, key_id, event_kind, last_event, input ready);
	modport sink (input valid, key_id, event_kind, last_event, output ready);
endinterface

interface khr_cfg_if;
	import khr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [THR_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/khr_lane.sv @@
// One key lane: hold counter and the events that one frame causes for that key.
`default_nettype none

module khr_lane (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      frame_en,
	input  wire                      clear,
	input  wire                      pressed,
	input  wire                      held,
	input  wire                      released,
	input  wire  [khr_pkg::THR_W-1:0] long_press,
	input  wire  [khr_pkg::THR_W-1:0] repeat_period,
	output khr_pkg::lane_ev_t        ev
);
	import khr_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] c1, c2, c3, c4;
	logic [CNT_W-1:0] long_ext;
	logic [CNT_W:0]   rep_thr;
	logic             hold_act, is_long, is_rep, rel_act, is_short;

	always_comb begin
		long_ext = {1'b0, long_press};
		rep_thr  = {2'b00, long_press} + {2'b00, repeat_period};
		c1       = (pressed && count_q != CNT_MAX) ? count_q + 8'd1 : count_q;
		hold_act = held && (c1 != '0);
		c2       = (hold_act && c1 != CNT_MAX) ? c1 + 8'd1 : c1;
		is_long  = hold_act && (c2 == long_ext);
		is_rep   = hold_act && !is_long && ({1'b0, c2} == rep_thr);
		c3       = is_rep ? long_ext : c2;
		rel_act  = released && (c3 != '0);
		is_short = rel_act && (c3 < long_ext);
		c4       = rel_act ? '0 : c3;
	end

	always_comb begin
		ev.press_ev = frame_en && pressed;
		ev.lr_ev    = frame_en && (is_long || is_rep);
		ev.rep_sel  = is_rep;
		ev.short_ev = frame_en && is_short;
		ev.rel_ev   = frame_en && rel_act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (frame_en) begin
			count_q <= c4;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/khr_merge.sv @@
// Event buffer merging the lane results, sent in key order one per cycle unless evt stalls.
`default_nettype none

module khr_merge #(
	parameter int KEYS = 6
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  khr_pkg::lane_ev_t lane_ev [KEYS],
	output logic              take_ok,
	khr_event_if.source       evt
);
	import khr_pkg::*;

	localparam int N  = KEYS * 4;
	localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int SW = KW + 2;

	logic [N-1:0]    pend_q;
	logic [KEYS-1:0] rep_q;
	logic [N-1:0]    new_pend;
	logic [KEYS-1:0] new_rep;
	logic [N-1:0]    rem;
	logic [SW-1:0]   sel;
	logic [KW-1:0]   key;
	logic            any, pop, rem_empty;
	ev_kind_t        kind;

	logic                 out_valid_q;
	logic [KEY_IDX_W-1:0] out_key_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic                 out_last_q;

	always_comb begin
		for (int k = 0; k < KEYS; k++) begin
			new_pend[4*k+0] = lane_ev[k].press_ev;
			new_pend[4*k+1] = lane_ev[k].lr_ev;
			new_pend[4*k+2] = lane_ev[k].short_ev;
			new_pend[4*k+3] = lane_ev[k].rel_ev;
			new_rep[k]      = lane_ev[k].rep_sel;
		end
	end

	always_comb begin
		sel = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SW'(i);
			end
		end
		any       = |pend_q;
		rem       = pend_q & ~(N'(1) << sel);
		rem_empty = (rem == '0);
		pop       = any && (!out_valid_q || evt.ready);
		take_ok   = !any || (pop && rem_empty);
		key       = sel[SW-1:2];
	end

	always_comb begin
		case (slot_t'(sel[1:0]))
			SLOT_PRESS:   kind = EV_PRESS;
			SLOT_LONGREP: kind = rep_q[key] ? EV_REPEAT : EV_LONG;
			SLOT_SHORT:   kind = EV_SHORT;
			SLOT_RELEASE: kind = EV_RELEASE;
			default:      kind = EV_PRESS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= new_pend;
		end else if (pop) begin
			pend_q <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rep_q <= new_rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_key_q  <= KEY_IDX_W'(key);
			out_kind_q <= kind;
			out_last_q <= rem_empty;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.key_id     = out_key_q;
	assign evt.event_kind = out_kind_q;
	assign evt.last_event = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/key_hold_repeat_event_generator_unit.sv @@
// Top level of the key hold and repeat event generator.
//
//   channel  role     handshake      payload
//   frame    sink     valid/ready    cmd, pressed_mask, held_mask, released_mask
//   evt      source   valid/ready    key_id, event_kind, last_event
//   cfg      sink     valid/ready    index, data (always ready)
//
// All key lanes update their counters in the cycle an unskipped data frame is accepted.
// The events of a frame leave through the merge buffer and output register one per cycle.
// A frame holds the buffer until its last event moves out; one with none leaves it empty.
// The next frame is taken when the buffer is empty or in the cycle its last event moves out.
// A stalled evt channel holds the output register and the buffer with its pending events.
// Reset clears all counters and the skip flag and sets the thresholds to 10 and 5.
`default_nettype none

module key_hold_repeat_event_generator_unit #(
	parameter int KEYS = 6
) (
	input  wire         clk,
	input  wire         arst_n,
	khr_frame_if.sink   frame,
	khr_event_if.source evt,
	khr_cfg_if.sink     cfg
);
	import khr_pkg::*;

	logic [THR_W-1:0] long_press_q;
	logic [THR_W-1:0] repeat_period_q;
	logic             skip_q;
	logic             take_ok;
	logic             accept, frame_en, clear;
	lane_ev_t         lane_ev [KEYS];

	assign frame.ready = take_ok;
	assign cfg.ready   = 1'b1;
	assign accept      = frame.valid && take_ok;
	assign clear       = accept && frame.cmd;
	assign frame_en    = accept && !frame.cmd && !skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q    <= LONG_PRESS_RESET;
			repeat_period_q <= REPEAT_PERIOD_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_LONG_PRESS) begin
				long_press_q <= cfg.data;
			end
			if (cfg.index == CFG_REPEAT_PERIOD) begin
				repeat_period_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (accept) begin
			skip_q <= frame.cmd;
		end
	end

	for (genvar k = 0; k < KEYS; k++) begin : g_lane
		logic p_bit, h_bit, r_bit;
		if (k < MASK_W) begin : g_bits
			assign p_bit = frame.pressed_mask[k];
			assign h_bit = frame.held_mask[k];
			assign r_bit = frame.released_mask[k];
		end else begin : g_none
			assign p_bit = 1'b0;
			assign h_bit = 1'b0;
			assign r_bit = 1'b0;
		end

		khr_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.frame_en      (frame_en),
			.clear         (clear),
			.pressed       (p_bit),
			.held          (h_bit),
			.released      (r_bit),
			.long_press    (long_press_q),
			.repeat_period (repeat_period_q),
			.ev            (lane_ev[k])
		);
	end

	khr_merge #(
		.KEYS (KEYS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (frame_en),
		.lane_ev (lane_ev),
		.take_ok (take_ok),
		.evt     (evt)
	);

endmodule

`default_nettype wire
